FILE: hw/rtl/cbb_pkg.sv
// ----------------------------------------------------------------------------
// cbb_pkg
// Shared types and constants of the circular byte buffer: opcodes, status
// codes, sequencer states and the control groups passed between modules.
// ----------------------------------------------------------------------------
package cbb_pkg;

   localparam int OP_W   = 3;
   localparam int CNT_W  = 7;
   localparam int BYTE_W = 8;
   localparam int STAT_W = 2;
   localparam int AMT_W  = 13;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE = 3'd0,
      OP_READ  = 3'd1,
      OP_PEEK  = 3'd2,
      OP_SKIP  = 3'd3,
      OP_CLEAR = 3'd4,
      OP_UNDO  = 3'd5
   } cbb_op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_SHORT   = 2'd1,
      STAT_ZERO    = 2'd2,
      STAT_REFUSED = 2'd3
   } cbb_status_type;

   typedef enum logic {
      SM_IDLE   = 1'b0,
      SM_STREAM = 1'b1
   } cbb_state_type;

   typedef struct packed {
      logic           valid;
      cbb_status_type status;
      logic [AMT_W-1:0] amount;
   } cbb_single_type;

   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] count;
   } cbb_start_type;

endpackage

FILE: hw/rtl/cbb_ram.sv
// ----------------------------------------------------------------------------
// cbb_ram
// Generic single-clock RAM, one write port and one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module cbb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/cbb_stream.sv
// ----------------------------------------------------------------------------
// cbb_stream
// Read streamer and output register. Issues one RAM read per cycle for a
// read or peek unless the output is stalled, carries the RAM data stage and
// merges single-result transactions into the response register.
// ----------------------------------------------------------------------------
module cbb_stream
   import cbb_pkg::*;
#(
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  cbb_start_type       start,
   input  logic [AW-1:0]       start_addr,
   input  cbb_single_type      single,
   output logic                ram_rd_en,
   output logic [AW-1:0]       ram_rd_addr,
   input  logic [BYTE_W-1:0]   ram_rd_data,
   output logic                busy,
   output logic                out_free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BYTE_W-1:0]   rsp_read_byte,
   output logic                rsp_last,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [AMT_W-1:0]    rsp_amount
);

   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [CNT_W-1:0]  amt_ff, amt_in;
   logic              s1_vld_ff, s1_vld_in;
   logic              s1_last_ff, s1_last_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   cbb_status_type    rsp_stat_ff, rsp_stat_in;
   logic [AMT_W-1:0]  rsp_amt_ff, rsp_amt_in;
   logic              s1_move;
   logic              issue;

   assign out_free    = !rsp_vld_ff || rsp_ready;
   assign s1_move     = s1_vld_ff && out_free;
   assign issue       = (rem_ff != '0) && (!s1_vld_ff || s1_move);
   assign ram_rd_en   = issue;
   assign ram_rd_addr = addr_ff;
   assign busy        = (rem_ff != '0) || s1_vld_ff;

   always_comb begin
      rem_in     = rem_ff;
      addr_in    = addr_ff;
      amt_in     = amt_ff;
      s1_vld_in  = s1_vld_ff;
      s1_last_in = s1_last_ff;
      if (start.valid) begin
         rem_in  = start.count;
         addr_in = start_addr;
         amt_in  = start.count;
      end else if (issue) begin
         rem_in     = rem_ff - CNT_W'(1);
         addr_in    = (addr_ff == AW'(DEPTH - 1)) ? '0 : addr_ff + AW'(1);
         s1_vld_in  = 1'b1;
         s1_last_in = (rem_ff == CNT_W'(1));
      end else if (s1_move) begin
         s1_vld_in = 1'b0;
      end
   end

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      rsp_stat_in = rsp_stat_ff;
      rsp_amt_in  = rsp_amt_ff;
      if (single.valid) begin
         rsp_vld_in  = 1'b1;
         rsp_byte_in = '0;
         rsp_last_in = 1'b1;
         rsp_stat_in = single.status;
         rsp_amt_in  = single.amount;
      end else if (s1_move) begin
         rsp_vld_in  = 1'b1;
         rsp_byte_in = ram_rd_data;
         rsp_last_in = s1_last_ff;
         rsp_stat_in = STAT_OK;
         rsp_amt_in  = AMT_W'(amt_ff);
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff     <= '0;
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         rem_ff     <= rem_in;
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      addr_ff     <= addr_in;
      amt_ff      <= amt_in;
      s1_last_ff  <= s1_last_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_amt_ff  <= rsp_amt_in;
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_read_byte = rsp_byte_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_status    = rsp_stat_ff;
   assign rsp_amount    = rsp_amt_ff;

endmodule

FILE: hw/rtl/circular_byte_buffer_top.sv
// ----------------------------------------------------------------------------
// circular_byte_buffer_top
// Byte ring buffer with all-or-nothing write, read, peek, skip, clear and
// undo-last-write requests, held in one synchronous RAM.
// ----------------------------------------------------------------------------
// A write run takes one byte transaction per cycle while the response
// register is free; bytes of an accepted run go straight into the RAM and
// the run's single result is produced as its final byte is taken; a refused
// write still takes all its bytes. Skip, clear, undo, zero-length and
// refused requests give one result each. A read or peek of N bytes streams
// N results at one byte per cycle through the RAM's single read port while
// the response side does not stall. The start registers the count and read
// address, the read is issued, the RAM registers the byte and it moves into
// the response register. The sequencer state register returns to idle once
// the streamer is no longer busy; no request is taken while it streams.
// Back-pressure on the response channel stalls the stream without losing
// bytes. The RAM needs no clearing pass: only written entries are ever read.
// ----------------------------------------------------------------------------
module circular_byte_buffer_top
   import cbb_pkg::*;
#(
   parameter int DEPTH       = 4096,
   parameter int MAX_REQUEST = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [CNT_W-1:0]  req_count,
   input  logic [BYTE_W-1:0] req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_read_byte,
   output logic              rsp_last,
   output logic [STAT_W-1:0] rsp_status,
   output logic [AMT_W-1:0]  rsp_amount
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(DEPTH + 1);
   localparam int SW = ((FW > CNT_W) ? FW : CNT_W) + 1;

   logic [AW-1:0]    rp_ff, rp_in;
   logic [AW-1:0]    wp_ff, wp_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic [CNT_W-1:0] prev_ff, prev_in;
   logic [CNT_W-1:0] wr_rem_ff, wr_rem_in;
   logic [CNT_W-1:0] wr_len_ff, wr_len_in;
   logic             wr_rej_ff, wr_rej_in;
   logic [AW-1:0]    wr_addr_ff, wr_addr_in;
   cbb_state_type    state_ff, state_in;

   logic             accept;
   logic             out_free;
   logic             busy;
   logic [SW-1:0]    free_space;
   cbb_op_type       op;
   cbb_single_type   single;
   cbb_start_type    start;
   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   logic             ram_rd_en;
   logic [AW-1:0]    ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p,
                                              input logic [SW-1:0] n);
      logic [SW-1:0] s;
      s = SW'(p) + n;
      if (s >= SW'(DEPTH)) begin
         s = s - SW'(DEPTH);
      end
      return AW'(s);
   endfunction

   function automatic logic [AW-1:0] wrap_sub(input logic [AW-1:0] p,
                                              input logic [SW-1:0] n);
      logic [SW-1:0] s;
      if (SW'(p) >= n) begin
         s = SW'(p) - n;
      end else begin
         s = SW'(p) + SW'(DEPTH) - n;
      end
      return AW'(s);
   endfunction

   assign accept     = req_valid && req_ready;
   assign op         = cbb_op_type'(req_opcode);
   assign free_space = SW'(DEPTH) - SW'(fill_ff);

   always_comb begin
      logic             take;
      logic [CNT_W-1:0] t_len;
      logic             t_rej;
      logic [AW-1:0]    t_addr;
      logic [CNT_W-1:0] t_rem;

      take        = 1'b0;
      t_len       = wr_len_ff;
      t_rej       = wr_rej_ff;
      t_addr      = wr_addr_ff;
      t_rem       = wr_rem_ff;
      rp_in       = rp_ff;
      wp_in       = wp_ff;
      fill_in     = fill_ff;
      prev_in     = prev_ff;
      wr_rem_in   = wr_rem_ff;
      wr_len_in   = wr_len_ff;
      wr_rej_in   = wr_rej_ff;
      wr_addr_in  = wr_addr_ff;
      single      = '{valid: 1'b0, status: STAT_OK, amount: '0};
      start       = '{valid: 1'b0, count: req_count};
      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_addr_ff;

      if (accept) begin
         if ((wr_rem_ff != '0) && (op == OP_WRITE)) begin
            take = 1'b1;
         end else begin
            wr_rem_in = '0;
            wr_rej_in = 1'b0;
            case (op)
               OP_WRITE: begin
                  if (req_count == '0) begin
                     single = '{valid: 1'b1, status: STAT_ZERO, amount: '0};
                  end else begin
                     take   = 1'b1;
                     t_len  = req_count;
                     t_rem  = req_count;
                     t_addr = wp_ff;
                     t_rej  = (req_count > CNT_W'(MAX_REQUEST)) ||
                              (SW'(req_count) > free_space);
                  end
               end
               OP_READ, OP_PEEK, OP_SKIP: begin
                  if (req_count == '0) begin
                     single = '{valid: 1'b1, status: STAT_ZERO, amount: '0};
                  end else if ((req_count > CNT_W'(MAX_REQUEST)) ||
                               (SW'(req_count) > SW'(fill_ff))) begin
                     single = '{valid: 1'b1, status: STAT_SHORT,
                                amount: AMT_W'(fill_ff)};
                  end else begin
                     if (op != OP_PEEK) begin
                        rp_in   = wrap_add(rp_ff, SW'(req_count));
                        fill_in = fill_ff - FW'(req_count);
                     end
                     if (op == OP_SKIP) begin
                        single = '{valid: 1'b1, status: STAT_OK,
                                   amount: AMT_W'(req_count)};
                     end else begin
                        start.valid = 1'b1;
                     end
                  end
               end
               OP_CLEAR: begin
                  rp_in   = '0;
                  wp_in   = '0;
                  fill_in = '0;
                  prev_in = '0;
                  single  = '{valid: 1'b1, status: STAT_OK, amount: '0};
               end
               OP_UNDO: begin
                  if ((prev_ff == '0) || (SW'(prev_ff) > SW'(fill_ff))) begin
                     single = '{valid: 1'b1, status: STAT_REFUSED, amount: '0};
                  end else begin
                     fill_in = fill_ff - FW'(prev_ff);
                     wp_in   = wrap_sub(wp_ff, SW'(prev_ff));
                     prev_in = '0;
                     single  = '{valid: 1'b1, status: STAT_OK,
                                 amount: AMT_W'(prev_ff)};
                  end
               end
               default: begin
               end
            endcase
         end
      end

      if (take) begin
         ram_wr_en   = !t_rej;
         ram_wr_addr = t_addr;
         wr_addr_in  = (t_addr == AW'(DEPTH - 1)) ? '0 : t_addr + AW'(1);
         wr_rem_in   = t_rem - CNT_W'(1);
         wr_len_in   = t_len;
         wr_rej_in   = t_rej;
         if (t_rem == CNT_W'(1)) begin
            wr_rej_in = 1'b0;
            if (t_rej) begin
               single = '{valid: 1'b1, status: STAT_SHORT,
                          amount: AMT_W'(free_space)};
            end else begin
               wp_in   = wrap_add(wp_ff, SW'(t_len));
               fill_in = fill_ff + FW'(t_len);
               prev_in = t_len;
               single  = '{valid: 1'b1, status: STAT_OK, amount: AMT_W'(t_len)};
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SM_IDLE: begin
            if (start.valid) begin
               state_in = SM_STREAM;
            end
         end
         SM_STREAM: begin
            if (!busy) begin
               state_in = SM_IDLE;
            end
         end
         default: state_in = SM_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == SM_IDLE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff     <= '0;
         wp_ff     <= '0;
         fill_ff   <= '0;
         prev_ff   <= '0;
         wr_rem_ff <= '0;
         wr_len_ff <= '0;
         wr_rej_ff <= 1'b0;
         state_ff  <= SM_IDLE;
      end else begin
         rp_ff     <= rp_in;
         wp_ff     <= wp_in;
         fill_ff   <= fill_in;
         prev_ff   <= prev_in;
         wr_rem_ff <= wr_rem_in;
         wr_len_ff <= wr_len_in;
         wr_rej_ff <= wr_rej_in;
         state_ff  <= state_in;
      end
      wr_addr_ff <= wr_addr_in;
   end

   cbb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_data_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cbb_stream #(
      .DEPTH (DEPTH)
   ) u_stream (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .start_addr    (rp_ff),
      .single        (single),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data),
      .busy          (busy),
      .out_free      (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_read_byte (rsp_read_byte),
      .rsp_last      (rsp_last),
      .rsp_status    (rsp_status),
      .rsp_amount    (rsp_amount)
   );

endmodule
